// ===== hw/rtl/smsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial mode string parser package
// Transfer types, status codes and the table of standard bit rates.
// ----------------------------------------------------------------------------
package smsp_pkg;

    localparam int NUM_RATES = 17;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_RATE   = 3'd1;
    localparam logic [2:0] ST_BAD_PARITY = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
    localparam logic [2:0] ST_BAD_STOP   = 3'd4;
    localparam logic [2:0] ST_BAD_FLOW   = 3'd5;

    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_ODD  = 2'd1;
    localparam logic [1:0] PAR_EVEN = 2'd2;

    localparam logic [1:0] FLOW_NONE = 2'd0;
    localparam logic [1:0] FLOW_XON  = 2'd1;
    localparam logic [1:0] FLOW_HW   = 2'd2;

    typedef struct packed {
        logic [7:0] character;
        logic       start_of_string;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  rate_index;
        logic [15:0] baud_rate;
        logic [1:0]  parity_mode;
        logic [3:0]  data_bits;
        logic        two_stop_bits;
        logic [1:0]  flow_mode;
    } t_out_item;

    function automatic logic [15:0] rate_value(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:    v = 16'd50;
            5'd1:    v = 16'd75;
            5'd2:    v = 16'd110;
            5'd3:    v = 16'd134;
            5'd4:    v = 16'd150;
            5'd5:    v = 16'd200;
            5'd6:    v = 16'd300;
            5'd7:    v = 16'd600;
            5'd8:    v = 16'd1050;
            5'd9:    v = 16'd1200;
            5'd10:   v = 16'd1800;
            5'd11:   v = 16'd2000;
            5'd12:   v = 16'd2400;
            5'd13:   v = 16'd4800;
            5'd14:   v = 16'd9600;
            5'd15:   v = 16'd19200;
            5'd16:   v = 16'd38400;
            default: v = 16'd50;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/smsp_rate_lookup.sv =====
// ----------------------------------------------------------------------------
// Rate lookup
// Matches the gathered rate against the standard rate table.
// ----------------------------------------------------------------------------
module smsp_rate_lookup (
    input  logic [15:0] i_rate,
    output logic        o_hit,
    output logic [4:0]  o_index
);

    always_comb begin
        o_hit   = 1'b0;
        o_index = '0;
        for (int k = 0; k < smsp_pkg::NUM_RATES; k++) begin
            if (i_rate == smsp_pkg::rate_value(5'(k))) begin
                o_hit   = 1'b1;
                o_index = 5'(k);
            end
        end
    end

endmodule

// ===== hw/rtl/smsp_parse.sv =====
// ----------------------------------------------------------------------------
// Parse core
// Holds the parse state and decodes one character per transfer.
// ----------------------------------------------------------------------------
module smsp_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  smsp_pkg::t_in_item   i_item,
    output logic                 o_res_valid,
    output smsp_pkg::t_out_item  o_res
);

    typedef enum logic [2:0] {
        PH_DIGITS, PH_SIZE, PH_STOP, PH_FLOW, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase;
    logic [15:0] r_acc, n_acc, cur_acc;
    logic [4:0]  r_ridx, n_ridx, cur_ridx;
    logic [1:0]  r_par, n_par, cur_par;
    logic [3:0]  r_size, n_size, cur_size;
    logic        r_stop, n_stop, cur_stop;

    logic [7:0]  c, u;
    logic        is_digit;
    logic [19:0] acc_x10;
    logic        rate_hit;
    logic [4:0]  rate_idx;

    assign c        = i_item.character;
    assign u        = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    assign is_digit = (c >= "0" && c <= "9");
    // times ten as two shifts, then add the digit
    assign acc_x10  = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
                    + {16'd0, c[3:0]};

    always_comb begin
        if (i_item.start_of_string) begin
            cur_phase = PH_DIGITS;
            cur_acc   = '0;
            cur_ridx  = '0;
            cur_par   = smsp_pkg::PAR_NONE;
            cur_size  = 4'd5;
            cur_stop  = 1'b0;
        end else begin
            cur_phase = r_phase;
            cur_acc   = r_acc;
            cur_ridx  = r_ridx;
            cur_par   = r_par;
            cur_size  = r_size;
            cur_stop  = r_stop;
        end
    end

    smsp_rate_lookup u_lookup (
        .i_rate  (cur_acc),
        .o_hit   (rate_hit),
        .o_index (rate_idx)
    );

    always_comb begin
        n_phase     = cur_phase;
        n_acc       = cur_acc;
        n_ridx      = cur_ridx;
        n_par       = cur_par;
        n_size      = cur_size;
        n_stop      = cur_stop;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (cur_phase)
            PH_DIGITS: begin
                if (is_digit) begin
                    n_acc = (acc_x10 > 20'd65535) ? 16'hFFFF : acc_x10[15:0];
                end else if (!rate_hit) begin
                    o_res_valid  = 1'b1;
                    o_res.status = smsp_pkg::ST_BAD_RATE;
                    n_phase      = PH_DONE;
                end else begin
                    n_ridx = rate_idx;
                    priority if (u == "N") begin
                        n_par   = smsp_pkg::PAR_NONE;
                        n_phase = PH_SIZE;
                    end else if (u == "O") begin
                        n_par   = smsp_pkg::PAR_ODD;
                        n_phase = PH_SIZE;
                    end else if (u == "E") begin
                        n_par   = smsp_pkg::PAR_EVEN;
                        n_phase = PH_SIZE;
                    end else begin
                        o_res_valid  = 1'b1;
                        o_res.status = smsp_pkg::ST_BAD_PARITY;
                        n_phase      = PH_DONE;
                    end
                end
            end
            PH_SIZE: begin
                if (c >= "5" && c <= "8") begin
                    n_size  = c[3:0];
                    n_phase = PH_STOP;
                end else begin
                    o_res_valid  = 1'b1;
                    o_res.status = smsp_pkg::ST_BAD_SIZE;
                    n_phase      = PH_DONE;
                end
            end
            PH_STOP: begin
                if (c == "1" || c == "2") begin
                    n_stop  = (c == "2");
                    n_phase = PH_FLOW;
                end else begin
                    o_res_valid  = 1'b1;
                    o_res.status = smsp_pkg::ST_BAD_STOP;
                    n_phase      = PH_DONE;
                end
            end
            PH_FLOW: begin
                o_res_valid = 1'b1;
                n_phase     = PH_DONE;
                if (u == "N" || u == "X" || u == "R" || c == 8'd0) begin
                    o_res.status        = smsp_pkg::ST_OK;
                    o_res.rate_index    = cur_ridx;
                    o_res.baud_rate     = smsp_pkg::rate_value(cur_ridx);
                    o_res.parity_mode   = cur_par;
                    o_res.data_bits     = cur_size;
                    o_res.two_stop_bits = cur_stop;
                    priority if (u == "X") begin
                        o_res.flow_mode = smsp_pkg::FLOW_XON;
                    end else if (u == "R") begin
                        o_res.flow_mode = smsp_pkg::FLOW_HW;
                    end else begin
                        o_res.flow_mode = smsp_pkg::FLOW_NONE;
                    end
                end else begin
                    o_res.status = smsp_pkg::ST_BAD_FLOW;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DIGITS;
            r_acc   <= '0;
            r_ridx  <= '0;
            r_par   <= smsp_pkg::PAR_NONE;
            r_size  <= 4'd5;
            r_stop  <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ridx  <= n_ridx;
            r_par   <= n_par;
            r_size  <= n_size;
            r_stop  <= n_stop;
        end
    end

endmodule

// ===== hw/rtl/serial_mode_string_parser.sv =====
// ----------------------------------------------------------------------------
// Serial mode string parser
// Decodes a settings string such as 9600n81x, one character per transfer.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one character and a start
// flag per transfer. Output channel: o_out_valid / i_out_stall carry one
// result per string: status plus the decoded rate, parity, size, stop and
// flow settings (all settings zero on a failure).
// A character is captured in an input register and decoded against the
// parse state; the result of the character that ends the string lands in
// an output register, from which it is offered. One character is taken
// per cycle while o_in_stall is low; the parse state update is a loop
// through the parse state registers and sets that rate.
// While the output register holds an untaken result, characters that give
// no result keep flowing; a character that would give a result waits in the
// input register, and o_in_stall rises while that register cannot drain.
// Reset empties both registers and leaves the parser ready for the digits
// of a rate, so the first string needs no start flag. Characters after a
// result are dropped until a start flag arrives.
// ----------------------------------------------------------------------------
module serial_mode_string_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  smsp_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output smsp_pkg::t_out_item  o_out_data
);

    logic                r_in_valid;
    smsp_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    smsp_pkg::t_out_item r_out_data;

    logic                res_valid;
    smsp_pkg::t_out_item res;
    logic                out_free;
    logic                advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !res_valid);
    assign o_in_stall = r_in_valid && !advance;

    smsp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (r_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= smsp_pkg::ST_BAD_FLOW)
        else $error("result status out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != smsp_pkg::ST_OK) |->
        (o_out_data.baud_rate == 16'd0 && o_out_data.rate_index == 5'd0 &&
         o_out_data.data_bits == 4'd0 && o_out_data.parity_mode == 2'd0 &&
         o_out_data.two_stop_bits == 1'b0 && o_out_data.flow_mode == 2'd0))
        else $error("failure result carries settings");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == smsp_pkg::ST_OK) |->
        (o_out_data.data_bits >= 4'd5 && o_out_data.data_bits <= 4'd8 &&
         o_out_data.baud_rate != 16'd0 && o_out_data.rate_index <= 5'd16))
        else $error("success result with bad settings");

    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) && !r_in_valid |=> !o_out_valid)
        else $error("result appeared without a character");

endmodule
